// ===== src/three_set_intersection_unit_defines.svh =====
// Assertion macros used by the RTL datapath file of the intersection unit.
`ifndef THREE_SET_INTERSECTION_UNIT_DEFINES_SVH
`define THREE_SET_INTERSECTION_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define TSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TSI_ASSERT_NEVER(lbl, cond, msg) \
  `TSI_ASSERT(lbl, !(cond), msg)
`else
`define TSI_ASSERT(lbl, prop, msg)
`define TSI_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== src/tsi_pkg.sv =====
`default_nettype none
package tsi_pkg;

  localparam int unsigned KeyWidth = 32;
  localparam int unsigned DefaultSlots = 256;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_FIRST  = 2'd1,
    MODE_SECOND = 2'd2,
    MODE_PROBE  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CHECK,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic                used;
    logic                first;
    logic                second;
    logic [KeyWidth-1:0] key;
  } entry_t;

  typedef struct packed {
    logic load_item;
    logic hash_step;
    logic seek;
    logic clr_wr;
    logic rd;
    logic adv;
    logic finish;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_clear;
    logic hash_done;
    logic clr_last;
    logic hit;
    logic empty;
    logic scan_last;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

// ===== src/three_set_intersection_unit.sv =====
// Channel   Direction  tdata          tuser
// s_axis    in         key_value[31:0] mode[1:0]
// m_axis    out        common_value   is_common[0], table_full[1]
//
// After reset a clearing pass over all TableSlots slots runs before the first transaction.
// A clear item sweeps the slot memory.
// Other items probe slots in turn from a home slot, which with a power-of-two table is the
// low key bits; otherwise the home slot comes from a reciprocal multiplication.
// The next item is taken while the result waits in the output register.
`default_nettype none
module three_set_intersection_unit #(
  parameter int unsigned TableSlots = tsi_pkg::DefaultSlots
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // key_value
  input  wire logic [1:0]  s_axis_tuser_i,   // mode
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // common_value
  output logic [1:0]       m_axis_tuser_o    // is_common, table_full
);

  tsi_pkg::cmd_t    cmd;
  tsi_pkg::status_t status;
  logic             common, full;

  tsi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tsi_datapath #(
    .TableSlots (TableSlots)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mode_i    (s_axis_tuser_i),
    .in_key_i     (s_axis_tdata_i),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_common_o (common),
    .out_full_o   (full),
    .out_value_o  (m_axis_tdata_o),
    .cmd_i        (cmd),
    .status_o     (status)
  );

  assign m_axis_tuser_o = {full, common};

endmodule
`default_nettype wire

// ===== src/tsi_ctrl.sv =====
`default_nettype none
module tsi_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire tsi_pkg::status_t status_i,
  output tsi_pkg::cmd_t       cmd_o
);

  tsi_pkg::state_e state_q, state_d;
  logic item_q, item_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsi_pkg::ST_CLEAR;
      item_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      item_q  <= item_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      tsi_pkg::ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        cmd_o.adv    = 1'b1;
        if (status_i.clr_last) begin
          state_d = item_q ? tsi_pkg::ST_FINISH : tsi_pkg::ST_IDLE;
        end
      end
      tsi_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          item_d = 1'b1;
          state_d = status_i.in_clear ? tsi_pkg::ST_CLEAR : tsi_pkg::ST_HASH;
        end
      end
      tsi_pkg::ST_HASH: begin
        if (status_i.hash_done) begin
          cmd_o.seek = 1'b1;
          state_d = tsi_pkg::ST_READ;
        end else begin
          cmd_o.hash_step = 1'b1;
        end
      end
      tsi_pkg::ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = tsi_pkg::ST_CHECK;
      end
      tsi_pkg::ST_CHECK: begin
        if (status_i.hit || status_i.empty || status_i.scan_last) begin
          cmd_o.finish = 1'b1;
          state_d = tsi_pkg::ST_FINISH;
        end else begin
          cmd_o.adv = 1'b1;
          state_d = tsi_pkg::ST_READ;
        end
      end
      tsi_pkg::ST_FINISH: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = tsi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tsi_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/tsi_datapath.sv =====
`default_nettype none
`include "three_set_intersection_unit_defines.svh"
module tsi_datapath #(
  parameter int unsigned TableSlots = tsi_pkg::DefaultSlots
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [1:0]                    in_mode_i,
  input  wire logic [tsi_pkg::KeyWidth-1:0]  in_key_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic                               out_common_o,
  output logic                               out_full_o,
  output logic [tsi_pkg::KeyWidth-1:0]       out_value_o,
  input  wire tsi_pkg::cmd_t                 cmd_i,
  output tsi_pkg::status_t                   status_o
);

  localparam int unsigned KW = tsi_pkg::KeyWidth;
  localparam int unsigned IW = $clog2(TableSlots);
  localparam bit IsPow2 = (TableSlots & (TableSlots - 1)) == 0;
  localparam logic [IW-1:0] LastIdx = IW'(TableSlots - 1);
  localparam int unsigned Shift = KW + IW - 1;
  localparam logic [KW-1:0] Recip = IsPow2 ? '0 :
      KW'((64'd1 << Shift) / 64'(TableSlots));
  localparam logic [KW-1:0] SlotsW = KW'(TableSlots);

  tsi_pkg::entry_t mem [TableSlots];
  tsi_pkg::entry_t rd_q, wdata;
  logic            we;

  logic [1:0]      mode_q;
  logic [KW-1:0]   key_q;
  logic [1:0]      hcnt_q;
  logic [2*KW-1:0] prod_q;
  logic [KW-1:0]   diff_q, quot;
  logic [IW-1:0]   home_q;
  logic [IW-1:0]   addr_q, step_q, home;
  logic            res_common_q, res_full_q;
  logic            out_valid_q, out_common_q, out_full_q;
  logic [KW-1:0]   out_value_q;
  logic            is_load, both, key_eq;

  assign is_load = (mode_q == tsi_pkg::MODE_FIRST) || (mode_q == tsi_pkg::MODE_SECOND);
  assign key_eq  = rd_q.key == key_q;
  assign both    = rd_q.first && rd_q.second;
  assign quot    = KW'(prod_q >> Shift);
  assign home    = IsPow2 ? key_q[IW-1:0] : home_q;

  assign status_o.in_clear  = in_mode_i == tsi_pkg::MODE_CLEAR;
  assign status_o.hash_done = IsPow2 || (hcnt_q == 2'd3);
  assign status_o.clr_last  = addr_q == LastIdx;
  assign status_o.hit       = rd_q.used && key_eq;
  assign status_o.empty     = !rd_q.used;
  assign status_o.scan_last = step_q == LastIdx;
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  always_comb begin
    we    = 1'b0;
    wdata = rd_q;
    if (cmd_i.clr_wr) begin
      we    = 1'b1;
      wdata = '0;
    end else if (cmd_i.finish) begin
      wdata.used = 1'b1;
      wdata.key  = key_q;
      if (mode_q == tsi_pkg::MODE_PROBE) begin
        we           = status_o.hit && both;
        wdata.first  = 1'b0;
        wdata.second = 1'b0;
      end else begin
        we = status_o.hit || status_o.empty;
        if (status_o.empty) begin
          wdata.first  = 1'b0;
          wdata.second = 1'b0;
        end
        if (mode_q == tsi_pkg::MODE_FIRST) begin
          wdata.first = 1'b1;
        end else begin
          wdata.second = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[addr_q] <= wdata;
    end
    if (cmd_i.rd) begin
      rd_q <= mem[addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mode_q <= in_mode_i;
      key_q  <= in_key_i;
      hcnt_q <= '0;
    end else if (cmd_i.hash_step) begin
      hcnt_q <= hcnt_q + 2'd1;
      prod_q <= {{KW{1'b0}}, key_q} * {{KW{1'b0}}, Recip};
      diff_q <= key_q - quot * SlotsW;
      home_q <= (diff_q >= SlotsW) ? IW'(diff_q - SlotsW) : IW'(diff_q);
    end
    if (cmd_i.load_item) begin
      res_common_q <= 1'b0;
      res_full_q   <= 1'b0;
    end else if (cmd_i.finish) begin
      res_common_q <= (mode_q == tsi_pkg::MODE_PROBE) && status_o.hit && both;
      res_full_q   <= is_load && !status_o.hit && !status_o.empty;
    end
    if (cmd_i.out_load) begin
      out_common_q <= res_common_q;
      out_full_q   <= res_full_q;
      out_value_q  <= res_common_q ? key_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_item) begin
        addr_q <= '0;
      end else if (cmd_i.seek) begin
        addr_q <= home;
        step_q <= '0;
      end else if (cmd_i.adv) begin
        addr_q <= (addr_q == LastIdx) ? '0 : addr_q + IW'(1);
        step_q <= step_q + IW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_common_o = out_common_q;
  assign out_full_o   = out_full_q;
  assign out_value_o  = out_value_q;

  `TSI_ASSERT(a_addr_range, addr_q <= LastIdx, "Slot address out of range.")
  `TSI_ASSERT_NEVER(a_common_and_full, cmd_i.out_load && res_common_q && res_full_q, "Bad flags.")
  `TSI_ASSERT(a_common_is_probe, cmd_i.finish && is_load |=> !res_common_q, "Load reported common.")

endmodule
`default_nettype wire

// ===== tb/three_set_intersection_checker.sv =====
`timescale 1ns / 1ps
module three_set_intersection_checker #(
  parameter int unsigned Slots = tsi_pkg::DefaultSlots
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  input  wire logic         s_axis_tready_i,
  input  wire logic [31:0]  s_axis_tdata_i,
  input  wire logic [1:0]   s_axis_tuser_i,
  input  wire logic         m_axis_tvalid_i,
  input  wire logic         m_axis_tready_i,
  input  wire logic [31:0]  m_axis_tdata_i,
  input  wire logic [1:0]   m_axis_tuser_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  typedef struct packed {
    logic        is_common;
    logic        table_full;
    logic [31:0] value;
  } verdict_t;

  logic [31:0] keys_q [Slots];
  bit          used_q [Slots];
  bit          first_q [Slots];
  bit          second_q [Slots];
  int unsigned occupancy;
  verdict_t    awaited [$];

  function automatic verdict_t membership_update(tsi_pkg::mode_e mode, logic [31:0] key);
    verdict_t    res;
    int unsigned idx;
    int unsigned slot;
    bit          found;
    res = '0;
    if (mode == tsi_pkg::MODE_CLEAR) begin
      for (int i = 0; i < Slots; i++) begin
        used_q[i] = 0;
        first_q[i] = 0;
        second_q[i] = 0;
      end
      occupancy = 0;
      return res;
    end
    idx = key % Slots;
    slot = Slots;
    found = 0;
    for (int n = 0; n < Slots; n++) begin
      if (!used_q[idx]) begin
        slot = idx;
        break;
      end
      if (keys_q[idx] == key) begin
        slot = idx;
        found = 1;
        break;
      end
      idx = (idx + 1) % Slots;
    end
    if (mode == tsi_pkg::MODE_PROBE) begin
      if (found && first_q[slot] && second_q[slot]) begin
        res.is_common = 1;
        res.value = key;
        first_q[slot] = 0;
        second_q[slot] = 0;
      end
      return res;
    end
    if (!found) begin
      if (slot >= Slots || occupancy >= Slots) begin
        res.table_full = 1;
        return res;
      end
      keys_q[slot] = key;
      used_q[slot] = 1;
      occupancy++;
    end
    if (mode == tsi_pkg::MODE_FIRST) first_q[slot] = 1;
    else second_q[slot] = 1;
    return res;
  endfunction

  initial begin
    fail_count_o = 0;
    occupancy = 0;
    for (int i = 0; i < Slots; i++) begin
      used_q[i] = 0;
      first_q[i] = 0;
      second_q[i] = 0;
    end
  end

  always @(posedge clk_i) begin
    verdict_t seen;
    verdict_t want;
    verdict_t fresh;
    if (rst_ni) begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        seen.is_common = m_axis_tuser_i[0];
        seen.table_full = m_axis_tuser_i[1];
        seen.value = m_axis_tdata_i;
        if (awaited.size() == 0) begin
          $display("%0t: unexpected transaction, actual %h", $time, seen);
          fail_count_o++;
        end else begin
          want = awaited.pop_front();
          if (seen.is_common !== want.is_common) begin
            $display("%0t: is_common expected %b actual %b", $time, want.is_common,
                     seen.is_common);
            fail_count_o++;
          end
          if (seen.table_full !== want.table_full) begin
            $display("%0t: table_full expected %b actual %b", $time, want.table_full,
                     seen.table_full);
            fail_count_o++;
          end
          if (seen.value !== want.value) begin
            $display("%0t: common_value expected %h actual %h", $time, want.value,
                     seen.value);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        fresh = membership_update(tsi_pkg::mode_e'(s_axis_tuser_i), s_axis_tdata_i);
        awaited = {awaited, fresh};
      end
    end
    pending_o = awaited.size();
  end
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned Slots = tsi_pkg::DefaultSlots;
  localparam int unsigned WatchdogLimit = 8000;
  localparam int unsigned ItemTarget = 1950;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned sent = 0;
  int unsigned quiet = 0;
  int unsigned stall_left = 0;
  bit          idling = 1;
  logic [31:0] pool [$];

  always #4 clk_i = ~clk_i;

  three_set_intersection_unit #(.TableSlots(Slots)) i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tuser_o(m_tuser)
  );

  three_set_intersection_checker #(.Slots(Slots)) i_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_i(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_i(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_i(m_tdata), .m_axis_tuser_i(m_tuser),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 0;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      m_tready <= 0;
    end else begin
      m_tready <= 1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send(tsi_pkg::mode_e mode, logic [31:0] key);
    if (idling && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_tvalid <= 1;
    s_tdata <= key;
    s_tuser <= mode;
    do @(posedge clk_i); while (!s_tready);
    sent++;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic random_phase(bit big);
    int unsigned n;
    logic [31:0] k;
    pool.delete();
    n = big ? Slots + $urandom_range(2, 10) : $urandom_range(2, 30);
    for (int i = 0; i < n; i++) begin
      k = $urandom;
      if (!big && $urandom_range(0, 1) == 0) k[7:0] = 8'($urandom_range(0, 3));
      pool = {pool, k};
    end
    send(tsi_pkg::MODE_CLEAR, $urandom);
    if (big) begin
      foreach (pool[i]) send(tsi_pkg::MODE_FIRST, pool[i]);
      for (int i = 0; i < 20; i++) send(tsi_pkg::MODE_SECOND, pool[i]);
      for (int i = 0; i < 30; i++) send(tsi_pkg::MODE_PROBE, pool[i]);
      send(tsi_pkg::MODE_PROBE, $urandom);
    end else begin
      repeat (3 * n) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7:
            send(tsi_pkg::MODE_FIRST, pool[$urandom_range(0, n - 1)]);
          8, 9, 10, 11, 12, 13, 14, 15:
            send(tsi_pkg::MODE_SECOND, pool[$urandom_range(0, n - 1)]);
          16, 17, 18: send(tsi_pkg::MODE_PROBE, pool[$urandom_range(0, n - 1)]);
          default: send(tsi_pkg::MODE_PROBE, $urandom);
        endcase
      end
    end
  endtask

  initial begin
    int unsigned phase;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send(tsi_pkg::MODE_CLEAR, 32'h0);
    send(tsi_pkg::MODE_FIRST, 32'h8000_0000);
    send(tsi_pkg::MODE_FIRST, 32'h7fff_ffff);
    send(tsi_pkg::MODE_SECOND, 32'h8000_0000);
    send(tsi_pkg::MODE_SECOND, 32'h7fff_ffff);
    send(tsi_pkg::MODE_PROBE, 32'h7fff_ffff);
    send(tsi_pkg::MODE_PROBE, 32'h7fff_ffff);
    send(tsi_pkg::MODE_PROBE, 32'h8000_0000);
    send(tsi_pkg::MODE_PROBE, 32'h0);
    send(tsi_pkg::MODE_FIRST, 32'h0);
    send(tsi_pkg::MODE_FIRST, 32'h0);
    send(tsi_pkg::MODE_PROBE, 32'h0);
    send(tsi_pkg::MODE_SECOND, 32'hffff_ffff);
    send(tsi_pkg::MODE_FIRST, 32'hffff_ffff);
    send(tsi_pkg::MODE_PROBE, 32'hffff_ffff);
    send(tsi_pkg::MODE_FIRST, 32'h0000_0100);
    send(tsi_pkg::MODE_FIRST, 32'h0000_0200);
    send(tsi_pkg::MODE_SECOND, 32'h0000_0200);
    send(tsi_pkg::MODE_SECOND, 32'h0000_0100);
    send(tsi_pkg::MODE_PROBE, 32'h0000_0200);
    send(tsi_pkg::MODE_PROBE, 32'h0000_0100);
    send(tsi_pkg::MODE_CLEAR, 32'hffff_ffff);
    send(tsi_pkg::MODE_PROBE, 32'h0000_0100);

    phase = 0;
    while (sent < ItemTarget) begin
      if (sent > ItemTarget - 200) idling = 0;
      random_phase(phase == 0 || $urandom_range(0, 24) == 0);
      if (phase == 1 || $urandom_range(0, 3) == 0) drain();
      phase++;
    end

    drain();
    repeat (600) @(posedge clk_i);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/tsi_pkg.sv
src/tsi_ctrl.sv
src/tsi_datapath.sv
src/three_set_intersection_unit.sv
tb/three_set_intersection_checker.sv
tb/testbench.sv
